// ===== src/obd_pid_response_decoder_assert.svh =====
// ----------------------------------------------------------------------------
// OBD PID response decoder assertion macros
// Shared assertion forms used by the decoder modules; each module that uses
// them has clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef OBD_PID_RESPONSE_DECODER_ASSERT_SVH
`define OBD_PID_RESPONSE_DECODER_ASSERT_SVH

// same-cycle implication
`define OBD_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define OBD_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/obd_pkg.sv =====
// ----------------------------------------------------------------------------
// OBD PID response decoder package
// Character codes, PID codes, line result type and helper functions.
// ----------------------------------------------------------------------------
package obd_pkg;

  localparam logic [7:0] CHR_CR     = 8'h0D;
  localparam logic [7:0] CHR_SPACE  = 8'h20;
  localparam logic [7:0] CHR_PROMPT = 8'h3E;
  localparam logic [7:0] HDR_MODE01 = 8'h41;

  localparam logic [3:0] PID_NONE = 4'd8;

  localparam logic [2:0] PID_LOAD     = 3'd0;
  localparam logic [2:0] PID_COOLANT  = 3'd1;
  localparam logic [2:0] PID_MAP      = 3'd2;
  localparam logic [2:0] PID_RPM      = 3'd3;
  localparam logic [2:0] PID_SPEED    = 3'd4;
  localparam logic [2:0] PID_INTAKE   = 3'd5;
  localparam logic [2:0] PID_MAF      = 3'd6;
  localparam logic [2:0] PID_THROTTLE = 3'd7;

  localparam int VALUE_W = 23;

  // floor(x / 255) and floor(x / 100) as (x * RECIP) >> RECIP_SHIFT
  localparam int          RECIP_SHIFT = 31;
  localparam logic [24:0] RECIP_255   = 25'd8421505;
  localparam logic [24:0] RECIP_100   = 25'd21474837;
  localparam logic [15:0] PCT_Q8      = 16'd25600;
  localparam logic [VALUE_W-1:0] TEMP_OFS_Q8 = 23'd10240;

  typedef struct packed {
    logic       hit;
    logic [2:0] code;
    logic [7:0] byte_a;
    logic [7:0] byte_b;
  } line_res_t;

  // {valid, nibble}
  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

  function automatic logic [3:0] map_pid(input logic [7:0] v);
    logic [3:0] r;
    unique case (v)
      8'h04:   r = {1'b0, PID_LOAD};
      8'h05:   r = {1'b0, PID_COOLANT};
      8'h0B:   r = {1'b0, PID_MAP};
      8'h0C:   r = {1'b0, PID_RPM};
      8'h0D:   r = {1'b0, PID_SPEED};
      8'h0F:   r = {1'b0, PID_INTAKE};
      8'h10:   r = {1'b0, PID_MAF};
      8'h11:   r = {1'b0, PID_THROTTLE};
      default: r = PID_NONE;
    endcase
    return r;
  endfunction

endpackage

// ===== src/obd_tok.sv =====
// ----------------------------------------------------------------------------
// OBD line tokenizer
// Splits the byte stream into tokens and lines, tracks header, PID and data
// bytes of the current line, and reports a decoded line on carriage return.
// ----------------------------------------------------------------------------
`include "obd_pid_response_decoder_assert.svh"

module obd_tok
  import obd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step_en,
  input  logic [7:0] rx_byte,
  output line_res_t  res
);

  logic [2:0] token_index_r, token_index_nxt;
  logic [7:0] token_value_r, token_value_nxt;
  logic [1:0] token_digits_r, token_digits_nxt;
  logic       token_bad_r, token_bad_nxt;
  logic       header_ok_r, header_ok_nxt;
  logic [3:0] pid_sel_r, pid_sel_nxt;
  logic [7:0] byte_a_r, byte_a_nxt;
  logic [7:0] byte_b_r, byte_b_nxt;

  logic       tok_nonempty;
  logic       tok_two;
  logic [7:0] tok_val;
  logic [2:0] cm_index;
  logic       cm_header;
  logic [3:0] cm_pid;
  logic [7:0] cm_a;
  logic [7:0] cm_b;
  logic [4:0] hex;

  // state after the open token is committed
  always_comb begin
    tok_nonempty = (token_digits_r != 2'd0) || token_bad_r;
    tok_two      = !token_bad_r && (token_digits_r == 2'd2);
    tok_val      = token_bad_r ? 8'd0 : token_value_r;
    cm_index     = token_index_r;
    cm_header    = header_ok_r;
    cm_pid       = pid_sel_r;
    cm_a         = byte_a_r;
    cm_b         = byte_b_r;
    if (tok_nonempty) begin
      unique case (token_index_r)
        3'd0:    cm_header = tok_two && (tok_val == HDR_MODE01);
        3'd1:    cm_pid    = tok_two ? map_pid(tok_val) : PID_NONE;
        3'd2:    cm_a      = tok_val;
        3'd3:    cm_b      = tok_val;
        default: ;
      endcase
      if (token_index_r != 3'd7) begin
        cm_index = token_index_r + 3'd1;
      end
    end
  end

  always_comb begin
    hex              = hex_val(rx_byte);
    token_index_nxt  = token_index_r;
    token_value_nxt  = token_value_r;
    token_digits_nxt = token_digits_r;
    token_bad_nxt    = token_bad_r;
    header_ok_nxt    = header_ok_r;
    pid_sel_nxt      = pid_sel_r;
    byte_a_nxt       = byte_a_r;
    byte_b_nxt       = byte_b_r;
    res.hit          = 1'b0;
    res.code         = cm_pid[2:0];
    res.byte_a       = cm_a;
    res.byte_b       = cm_b;
    priority if (rx_byte == CHR_PROMPT) begin
      // drop prompt
    end else if (rx_byte == CHR_SPACE) begin
      token_index_nxt  = cm_index;
      header_ok_nxt    = cm_header;
      pid_sel_nxt      = cm_pid;
      byte_a_nxt       = cm_a;
      byte_b_nxt       = cm_b;
      token_value_nxt  = 8'd0;
      token_digits_nxt = 2'd0;
      token_bad_nxt    = 1'b0;
    end else if (rx_byte == CHR_CR) begin
      res.hit          = cm_header && !cm_pid[3];
      token_index_nxt  = 3'd0;
      header_ok_nxt    = 1'b0;
      pid_sel_nxt      = PID_NONE;
      byte_a_nxt       = 8'd0;
      byte_b_nxt       = 8'd0;
      token_value_nxt  = 8'd0;
      token_digits_nxt = 2'd0;
      token_bad_nxt    = 1'b0;
    end else if (!hex[4] || token_digits_r == 2'd2) begin
      token_bad_nxt = 1'b1;
    end else begin
      token_value_nxt  = {token_value_r[3:0], hex[3:0]};
      token_digits_nxt = token_digits_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      token_index_r  <= 3'd0;
      token_value_r  <= 8'd0;
      token_digits_r <= 2'd0;
      token_bad_r    <= 1'b0;
      header_ok_r    <= 1'b0;
      pid_sel_r      <= PID_NONE;
      byte_a_r       <= 8'd0;
      byte_b_r       <= 8'd0;
    end else if (step_en) begin
      token_index_r  <= token_index_nxt;
      token_value_r  <= token_value_nxt;
      token_digits_r <= token_digits_nxt;
      token_bad_r    <= token_bad_nxt;
      header_ok_r    <= header_ok_nxt;
      pid_sel_r      <= pid_sel_nxt;
      byte_a_r       <= byte_a_nxt;
      byte_b_r       <= byte_b_nxt;
    end
  end

  `OBD_ASSERT_NXT(a_cr_clears_line, step_en && rx_byte == CHR_CR,
    token_index_r == 3'd0 && !header_ok_r && pid_sel_r == PID_NONE,
    "line state not cleared after carriage return")
  `OBD_ASSERT_IMP(a_digits_bound, 1'b1, token_digits_r != 2'd3,
    "token digit count out of range")
  `OBD_ASSERT_IMP(a_hit_needs_pid, res.hit, !cm_pid[3] && cm_header,
    "line hit without header and known PID")

endmodule

// ===== src/obd_scale.sv =====
// ----------------------------------------------------------------------------
// OBD value scaler
// Turns the data bytes of a reply into the Q8 value for its PID, using one
// shared reciprocal multiplier for the divisions by 255 and by 100.
// ----------------------------------------------------------------------------
module obd_scale
  import obd_pkg::*;
(
  input  logic [2:0]         code,
  input  logic [7:0]         byte_a,
  input  logic [7:0]         byte_b,
  output logic [VALUE_W-1:0] value_q8
);

  logic [15:0] word_ab;
  logic [23:0] pct_x;
  logic [23:0] mul_x;
  logic [24:0] mul_m;
  logic [48:0] prod;
  logic [17:0] quot;

  always_comb begin
    word_ab = {byte_a, byte_b};
    pct_x   = 24'(PCT_Q8) * 24'(byte_a);
    if (code == PID_MAF) begin
      mul_x = {word_ab, 8'd0};
      mul_m = RECIP_100;
    end else begin
      mul_x = pct_x;
      mul_m = RECIP_255;
    end
    prod = 49'(mul_x) * 49'(mul_m);
    quot = prod[RECIP_SHIFT +: 18];
  end

  always_comb begin
    unique case (code)
      PID_LOAD, PID_THROTTLE: value_q8 = VALUE_W'(quot);
      PID_COOLANT, PID_INTAKE: value_q8 = VALUE_W'({byte_a, 8'd0}) - TEMP_OFS_Q8;
      PID_MAP, PID_SPEED:     value_q8 = VALUE_W'({byte_a, 8'd0});
      PID_RPM:                value_q8 = VALUE_W'({word_ab, 6'd0});
      PID_MAF:                value_q8 = VALUE_W'(quot);
      default:                value_q8 = '0;
    endcase
  end

endmodule

// ===== src/obd_pid_response_decoder.sv =====
// ----------------------------------------------------------------------------
// OBD PID response decoder
// Decodes mode 01 PID replies from an adapter byte stream into PID code,
// Q8 value and milliseconds since the previous reply of the same PID.
// ----------------------------------------------------------------------------
// Each transfer on the input carries one received byte and the current time.
// Bytes pass an input register, then tokenizing, scaling and the elapsed-time
// subtraction run combinationally into the output register, so one byte is
// taken every cycle unless the output register stalls. A result is written to
// the output register when the input register holds the carriage return that
// ends its line. The output register stalls the input only while it holds a
// result that has not been taken.
// Lines that are not a known mode 01 reply produce no transfer.
`include "obd_pid_response_decoder_assert.svh"

module obd_pid_response_decoder
  import obd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // rx_byte[7:0], time_ms[39:8]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata   // pid_code[2:0], value_q8[25:3], elapsed_ms[57:26]
);

  logic        s0_valid_r;
  logic [7:0]  s0_byte_r;
  logic [31:0] s0_time_r;

  logic               out_valid_r;
  logic [2:0]         out_code_r;
  logic [VALUE_W-1:0] out_value_r;
  logic [31:0]        out_elapsed_r;

  logic [31:0] last_seen_r [8];

  logic               out_free;
  logic               fire;
  logic               in_xfer;
  line_res_t          line_res;
  logic [VALUE_W-1:0] value_q8;
  logic [31:0]        elapsed;

  assign out_free  = !out_valid_r || out_tready;
  assign fire      = s0_valid_r && out_free;
  assign in_tready = !s0_valid_r || out_free;
  assign in_xfer   = in_tvalid && in_tready;

  obd_tok u_tok (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (fire),
    .rx_byte (s0_byte_r),
    .res     (line_res)
  );

  obd_scale u_scale (
    .code     (line_res.code),
    .byte_a   (line_res.byte_a),
    .byte_b   (line_res.byte_b),
    .value_q8 (value_q8)
  );

  assign elapsed = s0_time_r - last_seen_r[line_res.code];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else if (in_tready) begin
      s0_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s0_byte_r <= in_tdata[7:0];
      s0_time_r <= in_tdata[39:8];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 8; i++) begin
        last_seen_r[i] <= 32'd0;
      end
    end else if (fire && line_res.hit) begin
      last_seen_r[line_res.code] <= s0_time_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire && line_res.hit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && line_res.hit) begin
      out_code_r    <= line_res.code;
      out_value_r   <= value_q8;
      out_elapsed_r <= elapsed;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_elapsed_r, out_value_r, out_code_r};

  `OBD_ASSERT_NXT(a_s0_hold, s0_valid_r && !out_free,
    s0_valid_r && $stable(s0_byte_r) && $stable(s0_time_r),
    "input register changed while stalled")
  `OBD_ASSERT_NXT(a_hit_to_out, fire && line_res.hit, out_valid_r,
    "decoded line not presented")
  `OBD_ASSERT_NXT(a_out_drain, out_valid_r && out_tready && !(fire && line_res.hit),
    !out_valid_r, "result repeated after transfer")

endmodule
